FILE: src/adc_channel_movavg_microvolts_macros.svh
// Assertion macros for the ADC moving-average block.
// Needs nothing else; included by the top level only.
`ifndef ADC_CHANNEL_MOVAVG_MICROVOLTS_MACROS_SVH
`define ADC_CHANNEL_MOVAVG_MICROVOLTS_MACROS_SVH

// same-cycle implication
`define ACM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/acm_pkg.sv
// Shared types, constants and codes for the ADC moving-average block.
// No dependencies; imported by every module.
package acm_pkg;

   localparam int CHANNELS   = 4;
   localparam int MAX_WINDOW = 16;

   localparam int CODE_W     = 24;
   localparam int CHAN_W     = 3;
   localparam int UV_W       = 28;
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W      = CODE_W + $clog2(MAX_WINDOW);
   localparam int RING_DEPTH = CHANNELS * MAX_WINDOW;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam int WIN_CFG_W  = 5;
   localparam int VREF_W     = 23;
   localparam int SNUM_W     = 5;
   localparam int SDEN_W     = 5;
   localparam int GAIN_W     = 7;
   localparam int CSR_DATA_W = 23;
   localparam int CSR_IDX_W  = 3;

   localparam int FS_SHIFT   = 23;
   localparam int GS_W       = GAIN_W + SDEN_W;
   localparam int PROD1_W    = CODE_W + VREF_W;
   localparam int DVD_W      = PROD1_W + SNUM_W;
   localparam int DVS_W      = GS_W + FS_SHIFT;
   localparam int STEP_W     = $clog2(DVD_W + 1);

   localparam logic [UV_W-1:0] UV_MAX_MAG = {1'b0, {(UV_W-1){1'b1}}};
   localparam logic [UV_W-1:0] UV_MIN_VAL = {1'b1, {(UV_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VREF       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_NUM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PGA_GAIN   = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TIMEOUT = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV1_GO,
      ST_DIV1_WAIT,
      ST_MUL1,
      ST_MUL2,
      ST_DIV2_GO,
      ST_DIV2_WAIT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [CODE_W-1:0] sample_code;
      logic              sample_valid;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        result_channel;
      status_type               status;
      logic signed [CODE_W-1:0] filtered_code;
      logic signed [UV_W-1:0]   microvolts;
   } rsp_type;

   typedef struct packed {
      logic                read;
      logic                update;
      logic                clear;
      logic [CH_IDX_W-1:0] chan;
      logic [FILL_W-1:0]   win;
      logic [CODE_W-1:0]   code;
   } hist_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [FILL_W-1:0]       fill;
   } hist_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: src/acm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on acm_pkg; dividends narrower than DVD_W come in left-aligned.
module acm_div import acm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: src/acm_hist.sv
// Per-channel sample history: ring memory, running sum, write index, fill count.
// Depends on acm_pkg; read a slot first, then update at the same slot.
module acm_hist import acm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hist_req_type hist_req,
   output hist_rsp_type hist_rsp
);

   logic signed [SUM_W-1:0] sum_ff [CHANNELS];
   logic [IDX_W-1:0]        idx_ff [CHANNELS];
   logic [FILL_W-1:0]       fill_ff [CHANNELS];
   logic [CODE_W-1:0]       ring [RING_DEPTH];
   logic [CODE_W-1:0]       rd_data_ff;

   logic signed [SUM_W-1:0] sum_in;
   logic [IDX_W-1:0]        idx_in;
   logic [FILL_W-1:0]       fill_in;
   logic [IDX_W-1:0]        idx_eff;
   logic [FILL_W-1:0]       idx_nxt;
   logic [RING_AW-1:0]      addr;
   logic                    full;
   logic signed [SUM_W-1:0] code_ext;
   logic signed [SUM_W-1:0] old_ext;

   always_comb begin
      idx_eff  = (FILL_W'(idx_ff[hist_req.chan]) >= hist_req.win) ? '0
                 : idx_ff[hist_req.chan];
      addr     = RING_AW'(RING_AW'(hist_req.chan) * RING_AW'(MAX_WINDOW)
                 + RING_AW'(idx_eff));
      full     = (fill_ff[hist_req.chan] >= hist_req.win);
      code_ext = {{(SUM_W-CODE_W){hist_req.code[CODE_W-1]}}, hist_req.code};
      old_ext  = {{(SUM_W-CODE_W){rd_data_ff[CODE_W-1]}}, rd_data_ff};
      sum_in   = sum_ff[hist_req.chan] + code_ext - (full ? old_ext : '0);
      fill_in  = full ? fill_ff[hist_req.chan] : fill_ff[hist_req.chan] + 1'b1;
      idx_nxt  = FILL_W'(idx_eff) + 1'b1;
      idx_in   = (idx_nxt >= hist_req.win) ? '0 : IDX_W'(idx_nxt);
   end

   always_ff @(posedge clock) begin
      if (reset || hist_req.clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]  <= '0;
            idx_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
      end else if (hist_req.update) begin
         sum_ff[hist_req.chan]  <= sum_in;
         idx_ff[hist_req.chan]  <= idx_in;
         fill_ff[hist_req.chan] <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_req.read) begin
         rd_data_ff <= ring[addr];
      end
      if (hist_req.update) begin
         ring[addr] <= hist_req.code;
      end
   end

   assign hist_rsp.sum  = sum_ff[hist_req.chan];
   assign hist_rsp.fill = fill_ff[hist_req.chan];

endmodule

FILE: src/adc_channel_movavg_microvolts.sv
// Top level: request sequencer, scaling multipliers, CSRs and output register.
// Depends on acm_pkg, acm_hist, acm_div and the assertion macro header.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_ready  req_data  (req_type)
//   rsp_        out        rsp_valid/rsp_ready  rsp_data  (rsp_type)
//   csr_        in         csr_we               csr_index, csr_wdata
//
// A new request is taken only once the previous one has gone to the response
// register. A valid request goes through the single serial divider, doing
// sum/count and then the microvolt scaling.
// Timeout and out-of-range requests skip the history and the divider and go
// straight from ST_IDLE to ST_FIN.
// The response register frees the input side: the next request is taken while
// a result waits; a finished request stalls only while the previous result is
// unaccepted. Reset is synchronous; the ring needs no clearing.
`include "adc_channel_movavg_microvolts_macros.svh"
module adc_channel_movavg_microvolts import acm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   state_type state_ff, state_in;

   logic [WIN_CFG_W-1:0] window_ff;
   logic [VREF_W-1:0]    vref_ff;
   logic [SNUM_W-1:0]    snum_ff;
   logic [SDEN_W-1:0]    sden_ff;
   logic [GAIN_W-1:0]    gain_ff;

   req_type                  req_ff;
   status_type               status_ff;
   logic                     neg_ff;
   logic [CODE_W-1:0]        fmag_ff;
   logic signed [CODE_W-1:0] filt_ff;
   logic [PROD1_W-1:0]       prod1_ff;
   logic [DVD_W-1:0]         prod2_ff;
   logic [GS_W-1:0]          gs_ff;
   logic [DVS_W-1:0]         den_ff;
   logic signed [UV_W-1:0]   uv_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   hist_req_type hist_req;
   hist_rsp_type hist_rsp;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   logic [FILL_W-1:0]  win;
   logic               accept;
   logic               out_free;
   logic               bad_chan;
   logic [SUM_W-1:0]   sum_mag;
   logic [GAIN_W-1:0]  gain_eff;
   logic [SDEN_W-1:0]  sden_eff;
   logic [DVD_W-1:0]   q;
   logic [UV_W-1:0]    uv_sat;

   acm_hist u_hist (
      .clock    (clock),
      .reset    (reset),
      .hist_req (hist_req),
      .hist_rsp (hist_rsp)
   );

   acm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (window_ff == '0) begin
         win = FILL_W'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         win = FILL_W'(MAX_WINDOW);
      end else begin
         win = FILL_W'(window_ff);
      end
      gain_eff = (gain_ff == '0) ? GAIN_W'(1) : gain_ff;
      sden_eff = (sden_ff == '0) ? SDEN_W'(1) : sden_ff;
      sum_mag  = hist_rsp.sum[SUM_W-1] ? SUM_W'(-hist_rsp.sum) : SUM_W'(hist_rsp.sum);
      bad_chan = (32'(req_data.channel) >= 32'(CHANNELS));
      q        = div_rsp.quotient;
      if (!neg_ff) begin
         uv_sat = (q > DVD_W'(UV_MAX_MAG)) ? UV_MAX_MAG : q[UV_W-1:0];
      end else begin
         uv_sat = (q > DVD_W'(UV_MIN_VAL)) ? UV_MIN_VAL : UV_W'(-q[UV_W-1:0]);
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      hist_req.read    = 1'b0;
      hist_req.update  = 1'b0;
      hist_req.clear   = csr_we && (csr_index == CSR_WINDOW_LEN);
      hist_req.chan    = req_ff.channel[CH_IDX_W-1:0];
      hist_req.win     = win;
      hist_req.code    = req_ff.sample_code;
      div_req.start    = 1'b0;
      div_req.dividend = DVD_W'(sum_mag) << (DVD_W - SUM_W);
      div_req.divisor  = DVS_W'(hist_rsp.fill);
      div_req.steps    = STEP_W'(SUM_W);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = (bad_chan || !req_data.sample_valid) ? ST_FIN : ST_READ;
            end
         end
         ST_READ: begin
            hist_req.read = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            hist_req.update = 1'b1;
            state_in        = ST_DIV1_GO;
         end
         ST_DIV1_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV1_WAIT;
         end
         ST_DIV1_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DIV2_GO;
         end
         ST_DIV2_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod2_ff + DVD_W'(den_ff >> 1);
            div_req.divisor  = den_ff;
            div_req.steps    = STEP_W'(DVD_W);
            state_in         = ST_DIV2_WAIT;
         end
         ST_DIV2_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_CFG_W'(1);
         vref_ff   <= VREF_W'(2500000);
         snum_ff   <= SNUM_W'(2);
         sden_ff   <= SDEN_W'(1);
         gain_ff   <= GAIN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEN: window_ff <= csr_wdata[WIN_CFG_W-1:0];
            CSR_VREF:       vref_ff   <= csr_wdata[VREF_W-1:0];
            CSR_SCALE_NUM:  snum_ff   <= csr_wdata[SNUM_W-1:0];
            CSR_SCALE_DEN:  sden_ff   <= csr_wdata[SDEN_W-1:0];
            CSR_PGA_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_data;
         filt_ff <= '0;
         uv_ff   <= '0;
         if (bad_chan) begin
            status_ff <= STATUS_RANGE;
         end else if (!req_data.sample_valid) begin
            status_ff <= STATUS_TIMEOUT;
         end else begin
            status_ff <= STATUS_OK;
         end
      end
      if (state_ff == ST_DIV1_GO) begin
         neg_ff <= hist_rsp.sum[SUM_W-1];
      end
      if (state_ff == ST_DIV1_WAIT && div_rsp.done) begin
         fmag_ff <= q[CODE_W-1:0];
         filt_ff <= neg_ff ? CODE_W'(-q[CODE_W-1:0]) : q[CODE_W-1:0];
      end
      if (state_ff == ST_MUL1) begin
         prod1_ff <= PROD1_W'(fmag_ff) * PROD1_W'(vref_ff);
         gs_ff    <= GS_W'(gain_eff) * GS_W'(sden_eff);
      end
      if (state_ff == ST_MUL2) begin
         prod2_ff <= DVD_W'(prod1_ff) * DVD_W'(snum_ff);
         den_ff   <= (DVS_W'(gs_ff) << FS_SHIFT) - DVS_W'(gs_ff);
      end
      if (state_ff == ST_DIV2_WAIT && div_rsp.done) begin
         uv_ff <= uv_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && out_free) begin
         rsp_data_ff.result_channel <= req_ff.channel;
         rsp_data_ff.status         <= status_ff;
         rsp_data_ff.filtered_code  <= filt_ff;
         rsp_data_ff.microvolts     <= uv_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ACM_ASSERT_IMPL(a_no_req_while_div, clock, reset, req_ready, !div_rsp.busy,
      "request taken while divider busy")
   `ACM_ASSERT_IMPL(a_fill_in_window, clock, reset, state_ff != ST_IDLE,
      hist_rsp.fill <= win, "fill count above window")
   `ACM_ASSERT_IMPL(a_bad_status_zero, clock, reset,
      rsp_valid && rsp_data.status != STATUS_OK,
      rsp_data.filtered_code == '0 && rsp_data.microvolts == '0,
      "nonzero result with error status")
   `ACM_ASSERT_NEXT(a_div_done_seq, clock, reset, div_rsp.done,
      state_ff == ST_MUL1 || state_ff == ST_FIN,
      "divider finished outside a wait state")

endmodule
